// File: sv/dpnn_pkg.sv
package dpnn_pkg;

    // Action codes carried in tuser
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int MEMBER_W = 6;
    localparam int ITEM_W   = 6;
    localparam int RATING_W = 4;
    localparam int SCORE_W  = 12;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 24;

    localparam int SCORE_MAX = 2047;
    localparam int SCORE_MIN = -2048;

    // Microprogram step addresses
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_CLR    = 4'd0;
    localparam step_t STEP_IDLE   = 4'd1;
    localparam step_t STEP_WR     = 4'd2;
    localparam step_t STEP_RD     = 4'd3;
    localparam step_t STEP_RDW    = 4'd4;
    localparam step_t STEP_QINIT  = 4'd5;
    localparam step_t STEP_QROW   = 4'd6;
    localparam step_t STEP_QRD    = 4'd7;
    localparam step_t STEP_DRAIN1 = 4'd8;
    localparam step_t STEP_DRAIN2 = 4'd9;
    localparam step_t STEP_QCMP   = 4'd10;
    localparam step_t STEP_QFIN   = 4'd11;
    localparam step_t STEP_OUT    = 4'd12;

    // Sequencing conditions
    typedef enum logic [3:0] {
        COND_NEXT,      // fall through
        COND_JUMP,      // always go to target
        COND_DISPATCH,  // wait for a beat, branch on action
        COND_CLR,       // stay until last clear address
        COND_NOROW,     // go to target when member is out of range
        COND_SELF,      // go to target when scanning the queried row
        COND_BLOOP,     // stay until last column issued
        COND_ULOOP,     // back to target until last row
        COND_OUTW       // stay until the output register frees
    } cond_t;

    // One control word
    typedef struct packed {
        cond_t cond;
        step_t target;
        logic  take;
        logic  clr_wr;
        logic  mem_wr;
        logic  rd_one;
        logic  ld_rd;
        logic  q_init;
        logic  row_init;
        logic  q_rd;
        logic  q_cmp;
        logic  q_fin;
        logic  ld_out;
    } ctrl_t;

    // Control store
    function automatic ctrl_t micro_rom(input step_t step);
        ctrl_t cw;
        cw = '0;
        cw.cond = COND_NEXT;
        cw.target = STEP_IDLE;
        case (step)
            STEP_CLR:
            begin
                cw.clr_wr = 1'b1;
                cw.cond = COND_CLR;
            end
            STEP_IDLE:
            begin
                cw.take = 1'b1;
                cw.cond = COND_DISPATCH;
            end
            STEP_WR:
            begin
                cw.mem_wr = 1'b1;
                cw.cond = COND_JUMP;
                cw.target = STEP_OUT;
            end
            STEP_RD:
            begin
                cw.rd_one = 1'b1;
            end
            STEP_RDW:
            begin
                cw.ld_rd = 1'b1;
                cw.cond = COND_JUMP;
                cw.target = STEP_OUT;
            end
            STEP_QINIT:
            begin
                cw.q_init = 1'b1;
                cw.cond = COND_NOROW;
                cw.target = STEP_OUT;
            end
            STEP_QROW:
            begin
                cw.row_init = 1'b1;
                cw.cond = COND_SELF;
                cw.target = STEP_QCMP;
            end
            STEP_QRD:
            begin
                cw.q_rd = 1'b1;
                cw.cond = COND_BLOOP;
            end
            STEP_DRAIN1:
            begin
                cw.cond = COND_NEXT;
            end
            STEP_DRAIN2:
            begin
                cw.cond = COND_NEXT;
            end
            STEP_QCMP:
            begin
                cw.q_cmp = 1'b1;
                cw.cond = COND_ULOOP;
                cw.target = STEP_QROW;
            end
            STEP_QFIN:
            begin
                cw.q_fin = 1'b1;
            end
            STEP_OUT:
            begin
                cw.ld_out = 1'b1;
                cw.cond = COND_OUTW;
                cw.target = STEP_IDLE;
            end
            default:
            begin
                cw.cond = COND_JUMP;
                cw.target = STEP_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// File: sv/dpnn_ram.sv
module dpnn_ram
    import dpnn_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [RATING_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]   rd_a_addr,
    output logic [RATING_W-1:0] rd_a_data,
    input  logic [ADDR_W-1:0]   rd_b_addr,
    output logic [RATING_W-1:0] rd_b_data
);

    logic [RATING_W-1:0] mem [DEPTH];

    // One write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports
    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// File: sv/dot_product_nearest_neighbor.sv
// Rating table of MEMBERS rows by ITEMS columns of signed 4-bit values with
// a most-similar-member query. Each input beat gives exactly one output beat.
// After reset the table is zeroed by a clearing pass over every cell, during
// which no beat is taken. A write goes through the write and output steps, a
// read through the read, read-wait and output steps, an unknown action straight
// to the output step. A query performs one multiply-accumulate per cycle,
// fed by the two read ports of the table memory, plus four steps of overhead
// per scanned row (row setup, two pipeline drain steps and the compare). The
// block is controlled by a microprogram and works on one beat at a time; a
// finished result waits in the output register while the next beat is taken.
module dot_product_nearest_neighbor
    import dpnn_pkg::*;
#(
    parameter int MEMBERS = 64,
    parameter int ITEMS   = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // member[5:0], item[11:6], rating_value[15:12]
    input  logic [IN_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [ACTION_W-1:0] s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // read_rating[3:0], best_member[9:4], best_score[21:10], zero [23:22]
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int DEPTH  = MEMBERS * ITEMS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int U_W    = $clog2(MEMBERS);
    localparam int B_W    = (ITEMS > 1) ? $clog2(ITEMS) : 1;
    localparam int SUM_W  = $clog2(64 * ITEMS + 1) + 1;
    localparam int ACC_W  = (SUM_W > SCORE_W) ? SUM_W : SCORE_W;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SCORE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SCORE_MIN);

    // Sequencer
    step_t upc_reg, upc_next;
    ctrl_t cw;

    // Latched request
    logic [MEMBER_W-1:0] member_reg;
    logic [ITEM_W-1:0]   item_reg;
    logic [RATING_W-1:0] rating_reg;

    // Counters and address bases
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] mbase_reg;
    logic [ADDR_W-1:0] ubase_reg;
    logic [U_W-1:0]    u_reg;
    logic [B_W-1:0]    b_reg;

    // MAC pipeline
    logic                     rd_v_reg;
    logic                     prod_v_reg;
    logic signed [7:0]        prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  best_reg;
    logic [U_W-1:0]           best_idx_reg;
    logic                     found_reg;

    // Result and output
    logic [RATING_W-1:0]     res_rating_reg;
    logic [MEMBER_W-1:0]     res_member_reg;
    logic [SCORE_W-1:0]      res_score_reg;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;

    logic accept;
    logic in_row, in_col, self_row;
    logic clr_last, b_last, u_last, out_free;
    logic [ADDR_W-1:0] cell_addr;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_wa;
    logic [RATING_W-1:0] ram_wd;
    logic [ADDR_W-1:0]   ram_ra;
    logic [ADDR_W-1:0]   ram_rb;
    logic [RATING_W-1:0] ram_qa;
    logic [RATING_W-1:0] ram_qb;
    logic signed [RATING_W-1:0] qa_s;
    logic signed [RATING_W-1:0] qb_s;

    assign cw = micro_rom(upc_reg);

    assign s_axis_tready = cw.take;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Range checks and loop ends
    assign in_row   = {26'd0, member_reg} < 32'(MEMBERS);
    assign in_col   = {26'd0, item_reg} < 32'(ITEMS);
    assign self_row = 32'(u_reg) == {26'd0, member_reg};
    assign clr_last = clr_reg == ADDR_W'(DEPTH - 1);
    assign b_last   = b_reg == B_W'(ITEMS - 1);
    assign u_last   = u_reg == U_W'(MEMBERS - 1);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign cell_addr = ADDR_W'(ADDR_W'(member_reg) * ADDR_W'(ITEMS) + ADDR_W'(item_reg));

    // Next step
    always_comb
    begin
        upc_next = upc_reg;
        case (cw.cond)
            COND_NEXT:
            begin
                upc_next = upc_reg + 1'b1;
            end
            COND_JUMP:
            begin
                upc_next = cw.target;
            end
            COND_DISPATCH:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        ACT_WRITE: upc_next = STEP_WR;
                        ACT_READ:  upc_next = STEP_RD;
                        ACT_QUERY: upc_next = STEP_QINIT;
                        default:   upc_next = STEP_OUT;
                    endcase
                end
            end
            COND_CLR:
            begin
                if (clr_last)
                begin
                    upc_next = upc_reg + 1'b1;
                end
            end
            COND_NOROW:
            begin
                upc_next = in_row ? upc_reg + 1'b1 : cw.target;
            end
            COND_SELF:
            begin
                upc_next = self_row ? cw.target : upc_reg + 1'b1;
            end
            COND_BLOOP:
            begin
                if (b_last)
                begin
                    upc_next = upc_reg + 1'b1;
                end
            end
            COND_ULOOP:
            begin
                upc_next = u_last ? upc_reg + 1'b1 : cw.target;
            end
            COND_OUTW:
            begin
                if (out_free)
                begin
                    upc_next = cw.target;
                end
            end
            default:
            begin
                upc_next = STEP_IDLE;
            end
        endcase
    end

    // Memory port steering
    always_comb
    begin
        ram_we = cw.clr_wr || (cw.mem_wr && in_row && in_col);
        ram_wa = cw.clr_wr ? clr_reg : cell_addr;
        ram_wd = cw.clr_wr ? '0 : rating_reg;
        ram_ra = cw.rd_one ? cell_addr : ADDR_W'(mbase_reg + ADDR_W'(b_reg));
        ram_rb = ADDR_W'(ubase_reg + ADDR_W'(b_reg));
    end

    dpnn_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (ram_we),
        .wr_addr   (ram_wa),
        .wr_data   (ram_wd),
        .rd_a_addr (ram_ra),
        .rd_a_data (ram_qa),
        .rd_b_addr (ram_rb),
        .rd_b_data (ram_qb)
    );

    assign qa_s = ram_qa;
    assign qb_s = ram_qb;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= STEP_CLR;
            clr_reg       <= '0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg    <= upc_next;
            rd_v_reg   <= cw.q_rd;
            prod_v_reg <= rd_v_reg;
            if (cw.clr_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cw.q_init)
            begin
                found_reg <= 1'b0;
            end
            else if (cw.q_cmp && !self_row && (!found_reg || acc_reg > best_reg))
            begin
                found_reg <= 1'b1;
            end
            if (cw.ld_out && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            member_reg     <= s_axis_tdata[5:0];
            item_reg       <= s_axis_tdata[11:6];
            rating_reg     <= s_axis_tdata[15:12];
            res_rating_reg <= '0;
            res_member_reg <= '0;
            res_score_reg  <= '0;
        end

        // single read result
        if (cw.ld_rd && in_row && in_col)
        begin
            res_rating_reg <= ram_qa;
        end

        // query setup
        if (cw.q_init)
        begin
            mbase_reg <= ADDR_W'(ADDR_W'(member_reg) * ADDR_W'(ITEMS));
            ubase_reg <= '0;
            u_reg     <= '0;
        end

        // column loop
        if (cw.row_init)
        begin
            b_reg <= '0;
        end
        else if (cw.q_rd)
        begin
            b_reg <= b_reg + 1'b1;
        end

        // multiply, then accumulate
        prod_reg <= 8'(qa_s) * 8'(qb_s);
        if (cw.row_init)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end

        // keep the first best row, then advance
        if (cw.q_cmp)
        begin
            if (!self_row && (!found_reg || acc_reg > best_reg))
            begin
                best_reg     <= acc_reg;
                best_idx_reg <= u_reg;
            end
            u_reg     <= u_reg + 1'b1;
            ubase_reg <= ADDR_W'(ubase_reg + ADDR_W'(ITEMS));
        end

        // saturate the reported score
        if (cw.q_fin && found_reg)
        begin
            res_member_reg <= MEMBER_W'(best_idx_reg);
            if (best_reg > SAT_HI)
            begin
                res_score_reg <= SCORE_W'(SAT_HI);
            end
            else if (best_reg < SAT_LO)
            begin
                res_score_reg <= SCORE_W'(SAT_LO);
            end
            else
            begin
                res_score_reg <= SCORE_W'(best_reg);
            end
        end

        if (cw.ld_out && out_free)
        begin
            out_data_reg <= {2'b00, res_score_reg, res_member_reg, res_rating_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // MAC pipeline is empty when a row score is compared
    assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == STEP_QCMP) |-> (!rd_v_reg && !prod_v_reg))
        else $error("row compared with products still in flight");

    // The table is never written while a query scans it
    assert property (@(posedge clk) disable iff (!rst_n)
        cw.q_rd |-> !ram_we)
        else $error("table write during query scan");

    // An in-range query always finds another member
    assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == STEP_QFIN) |-> found_reg)
        else $error("query finished without a candidate");

    // A held result stalls the sequencer at the output step
    assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == STEP_OUT && out_valid_reg && !m_axis_tready)
        |=> (upc_reg == STEP_OUT && $stable(out_data_reg)))
        else $error("pending result overwritten");

    // Last column issue leads into the drain steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (cw.q_rd && b_last) |=> (upc_reg == STEP_DRAIN1))
        else $error("column loop did not end");
`endif

endmodule

// File: verif/dpnn_checker.sv
// Watches both stream channels of the rating table block, keeps a shadow copy
// of the table, predicts one response per accepted input beat and compares
// each output beat against the oldest pending prediction.
module dpnn_checker
    import dpnn_pkg::*;
#(
    parameter int MEMBERS = 64,
    parameter int ITEMS   = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [IN_W-1:0]     in_data,
    input  logic [ACTION_W-1:0] in_action,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [OUT_W-1:0]    out_data,
    output int                  errors,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Output beat layout, LSB first: rating, member, score, pad
    typedef struct packed {
        logic [OUT_W-RATING_W-MEMBER_W-SCORE_W-1:0] pad;
        logic signed [SCORE_W-1:0]                  best_score;
        logic [MEMBER_W-1:0]                        best_member;
        logic signed [RATING_W-1:0]                 read_rating;
    } response_t;

    logic signed [RATING_W-1:0] ratings [MEMBERS][ITEMS];
    response_t                  pending_responses [$];
    int                         mismatches = 0;
    int                         beats_out  = 0;

    assign errors = mismatches;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    // Applies one request to the shadow table and returns the response it owes
    function automatic response_t table_response(
        input logic [ACTION_W-1:0]       act,
        input logic [MEMBER_W-1:0]       mem,
        input logic [ITEM_W-1:0]         col,
        input logic signed [RATING_W-1:0] val
    );
        response_t           res;
        int                  acc;
        int                  best;
        bit                  found;
        logic [MEMBER_W-1:0] best_idx;
        res      = '0;
        found    = 1'b0;
        best     = 0;
        best_idx = '0;
        case (act)
            ACT_WRITE:
            begin
                if (mem < MEMBERS && col < ITEMS)
                    ratings[mem][col] = val;
            end
            ACT_READ:
            begin
                if (mem < MEMBERS && col < ITEMS)
                    res.read_rating = ratings[mem][col];
            end
            ACT_QUERY:
            begin
                if (mem < MEMBERS)
                begin
                    // exact scores; strict greater-than keeps the lowest index on ties
                    for (int u = 0; u < MEMBERS; u++)
                    begin
                        if (u != mem)
                        begin
                            acc = 0;
                            for (int b = 0; b < ITEMS; b++)
                                acc += int'(ratings[mem][b]) * int'(ratings[u][b]);
                            if (!found || acc > best)
                            begin
                                found    = 1'b1;
                                best     = acc;
                                best_idx = u[MEMBER_W-1:0];
                            end
                        end
                    end
                    if (found)
                    begin
                        if (best > SCORE_MAX)
                            best = SCORE_MAX;
                        if (best < SCORE_MIN)
                            best = SCORE_MIN;
                        res.best_member = best_idx;
                        res.best_score  = best[SCORE_W-1:0];
                    end
                end
            end
            default:
            begin
                // unused action: no effect, all-zero response
            end
        endcase
        return res;
    endfunction

    // Predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        response_t seen;
        response_t want;
        if (!rst_n)
        begin
            for (int m = 0; m < MEMBERS; m++)
                for (int i = 0; i < ITEMS; i++)
                    ratings[m][i] = '0;
            pending_responses.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_responses.push_back(table_response(
                    in_action,
                    in_data[MEMBER_W-1:0],
                    in_data[MEMBER_W+ITEM_W-1:MEMBER_W],
                    in_data[IN_W-1:MEMBER_W+ITEM_W]));
            if (out_valid && out_ready)
            begin
                seen = out_data;
                if (pending_responses.size() == 0)
                    report_mismatch($sformatf("output beat %0d with nothing pending, data %h",
                                              beats_out, out_data));
                else
                begin
                    want = pending_responses.pop_front();
                    if (seen.read_rating !== want.read_rating ||
                        seen.best_member !== want.best_member ||
                        seen.best_score  !== want.best_score  ||
                        seen.pad         !== want.pad)
                        report_mismatch($sformatf(
                            "beat %0d got/exp rating %0d/%0d member %0d/%0d score %0d/%0d pad %0h/%0h",
                            beats_out, seen.read_rating, want.read_rating,
                            seen.best_member, want.best_member,
                            seen.best_score, want.best_score, seen.pad, want.pad));
                end
                beats_out = beats_out + 1;
            end
            outstanding <= pending_responses.size();
        end
    end

endmodule

// File: verif/tb.sv
// Stimulus and verdict for the rating table block; all checking is done in
// the checker instance.
module tb
    import dpnn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEMBERS     = 64;
    localparam int ITEMS       = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_TAIL  = 16;
    localparam int MIX_PER_PHASE = 13;

    // action code with no defined behavior
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic [ACTION_W-1:0] s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;

    int  errors;
    int  outstanding;
    int  gap_pct = 0;
    int  stall_pct = 0;
    logic rx_hold = 1'b0;
    logic hold_go = 1'b0;
    int  cycle_count = 0;
    int  n_writes = 0;
    int  n_reads = 0;
    int  n_queries = 0;
    int  n_unused = 0;

    always #5 clk = ~clk;

    dot_product_nearest_neighbor #(
        .MEMBERS(MEMBERS),
        .ITEMS  (ITEMS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    dpnn_checker #(
        .MEMBERS(MEMBERS),
        .ITEMS  (ITEMS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_action  (s_axis_tuser),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .errors     (errors),
        .outstanding(outstanding)
    );

    // Output side backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Long output stall so the block fills and blocks its input
    initial
    begin
        wait (hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses pending", cycle_count, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One input beat, with random idle cycles ahead of it
    task automatic offer_beat(
        input logic [ACTION_W-1:0] act,
        input logic [MEMBER_W-1:0] mem,
        input logic [ITEM_W-1:0]   col,
        input logic [RATING_W-1:0] val
    );
        while ($urandom_range(99, 0) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, col, mem};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (act)
            ACT_WRITE: n_writes++;
            ACT_READ:  n_reads++;
            ACT_QUERY: n_queries++;
            default:   n_unused++;
        endcase
    endtask

    initial
    begin : stimulus
        logic [MEMBER_W-1:0] pool [6];
        logic [MEMBER_W-1:0] mem;
        logic [ITEM_W-1:0]   col;
        logic [RATING_W-1:0] val;
        logic [ACTION_W-1:0] act;
        int                  off;
        int                  r;
        int                  phase;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extremes, ties, unused action
        offer_beat(ACT_READ,   6'd0,  6'd0,  4'sd0);   // never written, reads zero
        offer_beat(ACT_QUERY,  6'd0,  6'd0,  4'sd0);   // all-zero table: member 1 wins
        offer_beat(ACT_QUERY,  6'd63, 6'd63, 4'sd0);   // all-zero table: member 0 wins
        offer_beat(ACT_WRITE,  6'd0,  6'd0,  4'sd7);   // beyond -5..5, stored as is
        offer_beat(ACT_WRITE,  6'd63, 6'd63, 4'sb1000); // most negative code
        offer_beat(ACT_WRITE,  6'd1,  6'd0,  4'sd7);
        offer_beat(ACT_WRITE,  6'd2,  6'd0,  4'sb1000);
        offer_beat(ACT_READ,   6'd0,  6'd0,  4'sd0);
        offer_beat(ACT_READ,   6'd63, 6'd63, 4'sd0);
        offer_beat(ACT_QUERY,  6'd0,  6'd0,  4'sd0);
        offer_beat(ACT_WRITE,  6'd5,  6'd0,  4'sd7);   // ties with member 1
        offer_beat(ACT_QUERY,  6'd0,  6'd63, 4'sb1111);
        offer_beat(ACT_UNUSED, 6'd0,  6'd0,  4'sb1111); // must not write
        offer_beat(ACT_UNUSED, 6'd63, 6'd63, 4'sd7);
        offer_beat(ACT_READ,   6'd0,  6'd0,  4'sd0);
        offer_beat(ACT_WRITE,  6'd0,  6'd0,  4'sd5);
        offer_beat(ACT_READ,   6'd0,  6'd0,  4'sd0);
        offer_beat(ACT_WRITE,  6'd0,  6'd0,  -4'sd5);
        offer_beat(ACT_READ,   6'd0,  6'd0,  4'sd0);
        offer_beat(ACT_QUERY,  6'd2,  6'd0,  4'sd0);
        offer_beat(ACT_WRITE,  6'd2,  6'd0,  4'sd0);
        offer_beat(ACT_QUERY,  6'd2,  6'd0,  4'sd0);

        // Two fresh rows of -8 over 32 columns: score 2048 saturates.
        // Output held off at the start so the input backs up.
        pool[0] = 6'($urandom_range(62, 10));
        do
            pool[1] = 6'($urandom_range(62, 10));
        while (pool[1] == pool[0]);
        off = $urandom_range(63, 0);
        hold_go <= 1'b1;
        for (int k = 0; k < 32; k++)
        begin
            col = 6'((off + k) % ITEMS);
            offer_beat(ACT_WRITE, pool[0], col, 4'sb1000);
            offer_beat(ACT_WRITE, pool[1], col, 4'sb1000);
        end
        offer_beat(ACT_QUERY, pool[0], 6'($urandom_range(63, 0)), 4'($urandom));
        offer_beat(ACT_QUERY, pool[1], 6'($urandom_range(63, 0)), 4'($urandom));

        // Random mix over a small member pool, four handshake phases
        for (int p = 2; p < 6; p++)
            pool[p] = 6'($urandom_range(63, 0));
        for (int i = 0; i < 4 * MIX_PER_PHASE; i++)
        begin
            phase = i / MIX_PER_PHASE;
            case (phase)
                0:       begin gap_pct = 0;  stall_pct <= 0;  end
                1:       begin gap_pct = 88; stall_pct <= 0;  end
                2:       begin gap_pct = 0;  stall_pct <= 88; end
                default: begin gap_pct = 16; stall_pct <= 16; end
            endcase
            r   = $urandom_range(99, 0);
            mem = pool[$urandom_range(5, 0)];
            col = 6'($urandom_range(63, 0));
            val = 4'($urandom);
            if (r < 45)
                act = ACT_WRITE;
            else if (r < 70)
            begin
                act = ACT_READ;
                if (r % 2 == 1)
                    mem = 6'($urandom_range(63, 0));
            end
            else if (r < 82)
            begin
                act = ACT_QUERY;
                if (r == 70)
                    mem = 6'($urandom_range(63, 0));
            end
            else if (r < 88)
                act = ACT_UNUSED;
            else
            begin
                act = ACT_WRITE;
                mem = 6'($urandom_range(63, 0));
            end
            offer_beat(act, mem, col, val);
        end
        s_axis_tvalid <= 1'b0;

        // Let the last acceptance reach the pending count, then drain
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Ran %0d writes, %0d reads, %0d queries, %0d unused actions in %0d cycles,",
                 n_writes, n_reads, n_queries, n_unused, cycle_count);
        $display("covering empty-table and tie queries, full 4-bit ratings, score saturation "
                 , "and a long output stall.");
        if (errors == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
